// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands for the RTL of the interpolator core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge of clk, muted while arst_n is low.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check on every rising edge of clk, reset included.
`define ASSERT_ANY(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/bci_pkg.sv -----
// ----------------------------------------------------------------------------
// bci_pkg
// Breakpoint tables, widths and the divider item type of the charge
// interpolator.
// ----------------------------------------------------------------------------
package bci_pkg;

	// Field widths
	localparam int MV_W  = 16;   // pack voltage, millivolts
	localparam int PCT_W = 7;    // charge, percent

	// Stored breakpoint table
	localparam int STORED_POINTS = 11;
	localparam int IDX_W         = 4;   // holds a segment index up to STORED_POINTS-1

	// Interpolation widths: offset inside one segment is at most 1240 mV, the
	// percent step of one segment is 10, so the quotient stays below 16.
	localparam int OFF_W  = 11;
	localparam int DY_W   = 4;
	localparam int PROD_W = OFF_W + DY_W;
	localparam int QUOT_W = 4;
	localparam int CMP_W  = PROD_W + 1;

	typedef logic [MV_W-1:0]  mv_t;
	typedef logic [PCT_W-1:0] pct_t;

	localparam mv_t BP_MV [STORED_POINTS] = '{
		16'd9820, 16'd11060, 16'd11180, 16'd11300, 16'd11390, 16'd11510,
		16'd11620, 16'd11860, 16'd12070, 16'd12330, 16'd12600
	};

	localparam pct_t BP_PCT [STORED_POINTS] = '{
		7'd0, 7'd10, 7'd20, 7'd30, 7'd40, 7'd50,
		7'd60, 7'd70, 7'd80, 7'd90, 7'd100
	};

	// One item in flight through the divider
	typedef struct packed {
		logic [PROD_W-1:0] rem;    // partial remainder
		logic [OFF_W-1:0]  dx;     // segment width, never zero
		logic [QUOT_W-1:0] quot;   // quotient bits found so far
		pct_t              base;   // percent at the lower breakpoint
	} div_item_t;

endpackage

// ----- src/bci_div_pipe.sv -----
// ----------------------------------------------------------------------------
// bci_div_pipe
// Restoring divider, one quotient bit per pipeline stage, with its own
// valid/ready chain so bubbles are filled while the far end stalls.
// ----------------------------------------------------------------------------
module bci_div_pipe (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  bci_pkg::div_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output bci_pkg::div_item_t  out_item
);

	localparam int STAGES = bci_pkg::QUOT_W;

	bci_pkg::div_item_t item_s [STAGES];
	logic               vld_s  [STAGES];
	logic               en     [STAGES];

	genvar i;
	generate
		for (i = 0; i < STAGES; i++) begin : g_stage
			localparam int BIT = STAGES - 1 - i;

			bci_pkg::div_item_t         src;
			bci_pkg::div_item_t         nxt;
			logic                       src_vld;
			logic                       nxt_en;
			logic [bci_pkg::CMP_W-1:0]  dsh;
			logic [bci_pkg::CMP_W-1:0]  rem_x;

			// Pick the upstream stage
			if (i == 0) begin : g_first
				assign src     = in_item;
				assign src_vld = in_valid;
			end else begin : g_next
				assign src     = item_s[i-1];
				assign src_vld = vld_s[i-1];
			end

			// Pick the downstream enable
			if (i == STAGES - 1) begin : g_tail
				assign nxt_en = out_ready;
			end else begin : g_mid
				assign nxt_en = en[i+1];
			end

			assign en[i] = !vld_s[i] || nxt_en;

			// Try to subtract the shifted divisor for this quotient bit
			always_comb begin
				dsh   = bci_pkg::CMP_W'(src.dx) << BIT;
				rem_x = bci_pkg::CMP_W'(src.rem);
				nxt   = src;
				if (rem_x >= dsh) begin
					nxt.rem       = bci_pkg::PROD_W'(rem_x - dsh);
					nxt.quot[BIT] = 1'b1;
				end
			end

			// Advance valid
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[i] <= 1'b0;
				end else if (en[i]) begin
					vld_s[i] <= src_vld;
				end
			end

			// Advance payload
			always_ff @(posedge clk) begin
				if (en[i] && src_vld) begin
					item_s[i] <= nxt;
				end
			end
		end
	endgenerate

	assign in_ready  = en[0];
	assign out_valid = vld_s[STAGES-1];
	assign out_item  = item_s[STAGES-1];

endmodule

// ----- src/battery_charge_interpolator_core.sv -----
// ----------------------------------------------------------------------------
// battery_charge_interpolator_core
// Pack voltage to remaining charge by piecewise linear interpolation over a
// fixed breakpoint table.
// ----------------------------------------------------------------------------
// Channel   Dir  Bits  Contents
// s_*       in   16    voltage_mv
// m_*       out  8     charge_percent (bits 6:0), zero pad
//
// One transfer in per cycle and one result out per cycle while m_tready stays high.
// Stages: segment search, offset multiply, four divider stages (one quotient
// bit each), final add into the output register.
// Each stage has its own valid bit; a stage loads whenever it is empty or its
// successor advances, so a stall at m_tready holds everything and loses nothing.
// Reset clears the valid bits only.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module battery_charge_interpolator_core #(
	parameter int TABLE_POINTS = 11
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,    // [15:0] voltage_mv
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata     // [6:0] charge_percent, [7] zero
);

	// Breakpoints in use, clamped to the stored table
	localparam int N_USED = (TABLE_POINTS > bci_pkg::STORED_POINTS) ? bci_pkg::STORED_POINTS :
		((TABLE_POINTS < 2) ? 2 : TABLE_POINTS);

	// Stage 1 registers
	logic                       v_s1;
	bci_pkg::mv_t               volt_s1;
	logic [bci_pkg::IDX_W-1:0]  seg_s1;
	logic                       low_s1;
	logic                       high_s1;

	// Stage 2 registers
	logic                       v_s2;
	bci_pkg::div_item_t         item_s2;

	// Output stage
	logic                       v_s7;
	bci_pkg::pct_t              pct_s7;

	logic                       en_s1;
	logic                       en_s2;
	logic                       en_s7;
	logic                       div_in_ready;
	logic                       div_out_valid;
	bci_pkg::div_item_t         div_out_item;

	logic [bci_pkg::IDX_W-1:0]  seg_nx;
	logic                       low_nx;
	logic                       high_nx;

	logic [bci_pkg::IDX_W-1:0]  seg_lo;
	bci_pkg::mv_t               x0;
	bci_pkg::mv_t               dx_full;
	bci_pkg::pct_t              y0;
	bci_pkg::pct_t              y1;
	bci_pkg::pct_t              dy_full;
	logic [bci_pkg::OFF_W-1:0]  off;
	logic                       no_slope;
	bci_pkg::div_item_t         item_nx;

	// Stage enables: load when empty or when the next stage moves on
	assign en_s7    = !v_s7 || m_tready;
	assign en_s2    = !v_s2 || div_in_ready;
	assign en_s1    = !v_s1 || en_s2;
	assign s_tready = en_s1;

	// Stage 1: compare against every breakpoint, take the first not below
	always_comb begin
		low_nx  = (s_tdata <= bci_pkg::BP_MV[0]);
		high_nx = (s_tdata >= bci_pkg::BP_MV[N_USED-1]);
		seg_nx  = bci_pkg::IDX_W'(N_USED - 1);
		for (int j = N_USED - 2; j >= 1; j--) begin
			if (s_tdata <= bci_pkg::BP_MV[j]) begin
				seg_nx = bci_pkg::IDX_W'(j);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && s_tvalid) begin
			volt_s1 <= s_tdata;
			seg_s1  <= seg_nx;
			low_s1  <= low_nx;
			high_s1 <= high_nx;
		end
	end

	// Stage 2: segment lookup, offset and product; clamp cases divide zero
	always_comb begin
		seg_lo   = seg_s1 - bci_pkg::IDX_W'(1);
		x0       = bci_pkg::BP_MV[seg_lo];
		dx_full  = bci_pkg::BP_MV[seg_s1] - x0;
		y0       = bci_pkg::BP_PCT[seg_lo];
		y1       = bci_pkg::BP_PCT[seg_s1];
		dy_full  = y1 - y0;
		off      = bci_pkg::OFF_W'(volt_s1 - x0);
		no_slope = (dx_full == '0) || (y1 < y0);

		item_nx.quot = '0;
		item_nx.dx   = bci_pkg::OFF_W'(dx_full);
		item_nx.rem  = off * bci_pkg::DY_W'(dy_full);
		item_nx.base = y0;
		if (low_s1) begin
			item_nx.base = bci_pkg::BP_PCT[0];
		end else if (high_s1) begin
			item_nx.base = bci_pkg::BP_PCT[N_USED-1];
		end
		if (low_s1 || high_s1 || no_slope) begin
			item_nx.rem = '0;
			item_nx.dx  = bci_pkg::OFF_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			item_s2 <= item_nx;
		end
	end

	// Stages 3 to 6: quotient bits
	bci_div_pipe u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s2),
		.in_ready  (div_in_ready),
		.in_item   (item_s2),
		.out_valid (div_out_valid),
		.out_ready (en_s7),
		.out_item  (div_out_item)
	);

	// Output stage: add the quotient to the lower percentage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en_s7) begin
			v_s7 <= div_out_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s7 && div_out_valid) begin
			pct_s7 <= div_out_item.base + bci_pkg::PCT_W'(div_out_item.quot);
		end
	end

	assign m_tvalid = v_s7;
	assign m_tdata  = {1'b0, pct_s7};

	// Checks
	`ASSERT_ANY(a_pct_range, m_tvalid |-> (m_tdata[6:0] <= 7'd100), "charge above 100 percent")
	`ASSERT_CLK(a_quot_fits, v_s2 |-> (bci_pkg::CMP_W'(item_s2.rem) < (bci_pkg::CMP_W'(item_s2.dx) << bci_pkg::QUOT_W)), "quotient overflows divider")
	`ASSERT_CLK(a_s1_hold, (v_s1 && !en_s2) |=> (v_s1 && $stable(volt_s1)), "stage 1 lost data in stall")

endmodule

// ----- tb/sv/bci_charge_checker.sv -----
// ----------------------------------------------------------------------------
// bci_charge_checker
// Watches both stream channels of the charge interpolator. For every voltage
// transfer it computes the charge that must come out and queues it. Each
// result transfer is compared against the oldest queued charge. It hands the
// failure count and the number of charges still owed to the testbench top.
// ----------------------------------------------------------------------------
module bci_charge_checker #(
	parameter int TABLE_POINTS = 11
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,    // [15:0] voltage_mv
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,    // [6:0] charge_percent, [7] zero
	output int          fail_count,
	output int          pending
);

	// Discharge curve of a 3-cell lithium polymer pack, millivolts to percent
	localparam int KNEES = 11;
	localparam int unsigned KNEE_MV [KNEES] = '{
		9820, 11060, 11180, 11300, 11390, 11510,
		11620, 11860, 12070, 12330, 12600
	};
	localparam int unsigned KNEE_PCT [KNEES] = '{
		0, 10, 20, 30, 40, 50, 60, 70, 80, 90, 100
	};

	bci_pkg::pct_t charge_due [$];
	bci_pkg::pct_t want;
	int            errors;

	initial begin
		errors     = 0;
		fail_count = 0;
		pending    = 0;
	end

	// Charge in percent for one pack voltage
	function automatic bci_pkg::pct_t charge_for_voltage(input bci_pkg::mv_t mv);
		int unsigned npts;
		int unsigned seg;
		int unsigned lo_mv;
		int unsigned hi_mv;
		int unsigned lo_pct;
		int unsigned hi_pct;
		int unsigned span;
		int unsigned v;
		v    = mv;
		npts = TABLE_POINTS;
		// only the stored curve exists; a segment needs two knees
		if (npts > KNEES)
			npts = KNEES;
		if (npts < 2)
			npts = 2;
		if (v <= KNEE_MV[0])
			return bci_pkg::pct_t'(KNEE_PCT[0]);
		if (v >= KNEE_MV[npts-1])
			return bci_pkg::pct_t'(KNEE_PCT[npts-1]);
		// first knee not below the voltage closes the segment
		seg = 1;
		while (seg < npts - 1 && v > KNEE_MV[seg])
			seg++;
		lo_mv  = KNEE_MV[seg-1];
		hi_mv  = KNEE_MV[seg];
		lo_pct = KNEE_PCT[seg-1];
		hi_pct = KNEE_PCT[seg];
		span   = hi_mv - lo_mv;
		if (span == 0 || hi_pct < lo_pct)
			return bci_pkg::pct_t'(lo_pct);
		return bci_pkg::pct_t'(lo_pct + ((v - lo_mv) * (hi_pct - lo_pct)) / span);
	endfunction

	task automatic report_miss(input string what);
		errors++;
		$display("%0t: charge check: %s", $time, what);
	endtask

	// Retire the oldest charge on a result transfer, queue one per voltage transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (charge_due.size() == 0) begin
					report_miss($sformatf("result 0x%02h with no charge owed", m_tdata));
				end else begin
					want = charge_due.pop_front();
					if (m_tdata[6:0] !== want)
						report_miss($sformatf("charge %0d, want %0d", m_tdata[6:0], want));
					if (m_tdata[7] !== 1'b0)
						report_miss($sformatf("pad bit is %b", m_tdata[7]));
				end
			end
			if (s_tvalid && s_tready)
				charge_due.push_back(charge_for_voltage(s_tdata));
		end
		fail_count <= errors;
		pending    <= charge_due.size();
	end

endmodule

// ----- tb/sv/battery_charge_interpolator_core_test.sv -----
// ----------------------------------------------------------------------------
// battery_charge_interpolator_core_test
// Drives pack voltages into the charge interpolator: knees, their neighbors
// and the field extremes first, then random voltages weighted toward the
// curve. Both sides idle at random, with a long stretch at full rate, one long
// receiver hold-off and one drain pause. A checker beside the block predicts
// and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module battery_charge_interpolator_core_test;

	localparam int TABLE_POINTS = 11;
	localparam int RANDOM_ITEMS = 380;
	localparam int FULL_RATE    = 120;    // random items sent with no idling
	localparam int HOLD_ITEMS   = 30;     // items offered while the receiver holds off
	localparam int HOLD_CYCLES  = 80;
	localparam int IDLE_PCT     = 19;
	localparam int QUIET_LIMIT  = 2000;   // cycles with no transfer before giving up
	localparam int LATENCY      = 7;

	localparam int CORNERS = 21;
	localparam bci_pkg::mv_t CORNER_MV [CORNERS] = '{
		16'd0, 16'd65535, 16'd9819, 16'd9820, 16'd9821,
		16'd11060, 16'd11180, 16'd11300, 16'd11390, 16'd11510,
		16'd11620, 16'd11860, 16'd12070, 16'd12330, 16'd12600,
		16'd11059, 16'd11061, 16'd12599, 16'd12601, 16'd10440, 16'd32768
	};

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata  = '0;      // [15:0] voltage_mv
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;            // [6:0] charge_percent, [7] zero

	int fail_count;
	int pending;
	bit gaps_on  = 1'b1;
	bit hold_ask = 1'b0;

	battery_charge_interpolator_core #(
		.TABLE_POINTS(TABLE_POINTS)
	) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	bci_charge_checker #(
		.TABLE_POINTS(TABLE_POINTS)
	) charge_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.fail_count(fail_count),
		.pending   (pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Random voltage: mostly on the curve, some close to a knee, the rest anywhere
	function automatic bci_pkg::mv_t pick_voltage();
		int unsigned roll;
		int unsigned k;
		roll = $urandom_range(99);
		if (roll < 70)
			return bci_pkg::mv_t'($urandom_range(12600, 9820));
		if (roll < 85) begin
			k = $urandom_range(10);
			return bci_pkg::mv_t'(int'(bci_pkg::BP_MV[k]) + int'($urandom_range(6)) - 3);
		end
		return bci_pkg::mv_t'($urandom_range(65535));
	endfunction

	// Offer one voltage and hold it until the transfer
	task automatic offer_voltage(input bci_pkg::mv_t mv);
		while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			s_tdata  <= bci_pkg::mv_t'($urandom_range(65535));
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= mv;
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	// Stop offering and wait for every owed charge to arrive
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// Receiver: random stalls, or one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_ask) begin
				hold_ask = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			m_tready <= !gaps_on || $urandom_range(99) >= IDLE_PCT;
		end
	end

	// Give up after a long stretch with no transfer on either side
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Some tests failed");
		$finish;
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// knees, their neighbors and the field extremes
		foreach (CORNER_MV[i])
			offer_voltage(CORNER_MV[i]);

		// fill the pipeline against a held receiver, then drain it
		hold_ask = 1'b1;
		for (int i = 0; i < HOLD_ITEMS; i++)
			offer_voltage(pick_voltage());
		drain();

		// random voltages, the first stretch at full rate
		gaps_on = 1'b0;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == FULL_RATE)
				gaps_on = 1'b1;
			offer_voltage(pick_voltage());
		end
		drain();
		repeat (LATENCY * 2) @(posedge clk);

		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
